@@ hdl/kr_pkg.sv @@
package kr_pkg;

    localparam int SLOTS     = 6;
    localparam int BLOCKS    = 4;
    localparam int KEY_W     = 32;
    localparam int BASE_W    = 16;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [BASE_W-1:0] t_base;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_idx  IDX_LAST       = t_idx'(SLOTS - 1);
    localparam t_blk  BLK_LAST       = t_blk'(BLOCKS - 1);
    localparam t_base BLOCK_SIZE_RST = t_base'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_START,
        CFG_BLOCK_SIZE
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_STORE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_idx  idx;
        logic  wr;
        logic  shift;
        t_key  key;
        t_base base;
    } t_tbl_ctrl;

    typedef struct packed {
        logic  hit;
        logic  empty;
        t_base base;
    } t_tbl_stat;

endpackage

@@ hdl/kr_req_if.sv @@
interface kr_req_if;
    import kr_pkg::*;

    logic valid;
    logic ready;
    t_key owner_key;

    modport source (output valid, output owner_key, input ready);
    modport sink   (input valid, input owner_key, output ready);
endinterface

@@ hdl/kr_rsp_if.sv @@
interface kr_rsp_if;
    import kr_pkg::*;

    logic  valid;
    logic  ready;
    t_base region_base;
    logic  was_found;
    logic  evicted_oldest;

    modport source (output valid, output region_base, output was_found,
                    output evicted_oldest, input ready);
    modport sink   (input valid, input region_base, input was_found,
                    input evicted_oldest, output ready);
endinterface

@@ hdl/key_to_region_map_fifo_evict_core.sv @@
// channel | dir | handshake     | payload
// i_req   | in  | valid / ready | owner_key[31:0]
// o_rsp   | out | valid / ready | region_base[15:0], was_found, evicted_oldest
// i_cfg   | in  | write enable  | idx 0: pool_start, idx 1: block_size
//
// A request steps through accept, one slot compare per cycle over up to 6
// slots in the shared key comparator (none for a null key), a multiply step
// and a store step for a new key, then a load of the response register.
// Reset clears the table, the allocation counter, the block index and pool_start, and sets block_size to 256.
// The response register holds a result while o_rsp stalls; the next request
// is accepted meanwhile and waits in its final step until the register frees.
module key_to_region_map_fifo_evict_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    kr_req_if.sink                       i_req,
    kr_rsp_if.source                     o_rsp,
    input  logic                         i_cfg_we,
    input  logic [kr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kr_pkg::CFG_W-1:0]     i_cfg_data
);
    import kr_pkg::*;

    t_tbl_ctrl w_ctrl;
    t_tbl_stat w_stat;

    kr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctrl     (w_ctrl),
        .i_stat     (w_stat)
    );

    kr_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

endmodule

@@ hdl/kr_table.sv @@
module kr_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kr_pkg::t_tbl_ctrl i_ctrl,
    output kr_pkg::t_tbl_stat o_stat
);
    import kr_pkg::*;

    t_key  r_key  [SLOTS];
    t_base r_base [SLOTS];

    always_comb begin
        o_stat.hit   = (r_key[i_ctrl.idx] == i_ctrl.key);
        o_stat.empty = (r_key[i_ctrl.idx] == '0);
        o_stat.base  = r_base[i_ctrl.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_key[k]  <= '0;
                r_base[k] <= '0;
            end
        end else if (i_ctrl.wr) begin
            if (i_ctrl.shift) begin
                for (int k = 0; k < SLOTS - 1; k++) begin
                    r_key[k]  <= r_key[k+1];
                    r_base[k] <= r_base[k+1];
                end
                r_key[SLOTS-1]  <= i_ctrl.key;
                r_base[SLOTS-1] <= i_ctrl.base;
            end else begin
                r_key[i_ctrl.idx]  <= i_ctrl.key;
                r_base[i_ctrl.idx] <= i_ctrl.base;
            end
        end
    end

endmodule

@@ hdl/kr_seq.sv @@
module kr_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kr_req_if.sink                        i_req,
    kr_rsp_if.source                      o_rsp,
    input  logic                          i_cfg_we,
    input  logic [kr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kr_pkg::CFG_W-1:0]      i_cfg_data,
    output kr_pkg::t_tbl_ctrl             o_ctrl,
    input  kr_pkg::t_tbl_stat             i_stat
);
    import kr_pkg::*;

    t_state r_state, n_state;
    t_key   r_key, n_key;
    t_idx   r_idx, n_idx;
    logic   r_evict, n_evict;
    t_base  r_prod, n_prod;
    t_cnt   r_alloc, n_alloc;
    t_blk   r_blk, n_blk;
    t_base  r_pool, r_bsize;
    t_base  r_res_base, n_res_base;
    logic   r_res_found, n_res_found;
    logic   r_res_evict, n_res_evict;
    logic   r_ov, n_ov;
    t_base  r_o_base, n_o_base;
    logic   r_o_found, n_o_found;
    logic   r_o_evict, n_o_evict;

    logic [BLK_W+BASE_W-1:0] w_prod;
    t_base                   w_sum;

    assign w_prod = r_blk * r_bsize;
    assign w_sum  = r_pool + r_prod;

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.region_base    = r_o_base;
    assign o_rsp.was_found      = r_o_found;
    assign o_rsp.evicted_oldest = r_o_evict;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_idx       = r_idx;
        n_evict     = r_evict;
        n_prod      = r_prod;
        n_alloc     = r_alloc;
        n_blk       = r_blk;
        n_res_base  = r_res_base;
        n_res_found = r_res_found;
        n_res_evict = r_res_evict;
        n_ov        = r_ov;
        n_o_base    = r_o_base;
        n_o_found   = r_o_found;
        n_o_evict   = r_o_evict;

        o_ctrl.idx   = r_idx;
        o_ctrl.wr    = 1'b0;
        o_ctrl.shift = r_evict;
        o_ctrl.key   = r_key;
        o_ctrl.base  = w_sum;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key = i_req.owner_key;
                    n_idx = '0;
                    if (i_req.owner_key == '0) begin
                        n_res_base  = r_pool;
                        n_res_found = 1'b0;
                        n_res_evict = 1'b0;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_res_base  = i_stat.base;
                    n_res_found = 1'b1;
                    n_res_evict = 1'b0;
                    n_state     = S_DONE;
                end else if (i_stat.empty) begin
                    n_evict = 1'b0;
                    n_state = S_CALC;
                end else if (r_idx == IDX_LAST) begin
                    n_evict = 1'b1;
                    n_state = S_CALC;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_CALC: begin
                n_prod  = w_prod[BASE_W-1:0];
                n_state = S_STORE;
            end
            S_STORE: begin
                o_ctrl.wr   = 1'b1;
                n_res_base  = w_sum;
                n_res_found = 1'b0;
                n_res_evict = r_evict;
                n_alloc     = r_alloc + t_cnt'(1);
                if (r_alloc == '1 || r_blk == BLK_LAST) begin
                    n_blk = '0;
                end else begin
                    n_blk = r_blk + t_blk'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov      = 1'b1;
                    n_o_base  = r_res_base;
                    n_o_found = r_res_found;
                    n_o_evict = r_res_evict;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_alloc <= '0;
            r_blk   <= '0;
            r_pool  <= '0;
            r_bsize <= BLOCK_SIZE_RST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_alloc <= n_alloc;
            r_blk   <= n_blk;
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_POOL_START: r_pool  <= i_cfg_data[BASE_W-1:0];
                    CFG_BLOCK_SIZE: r_bsize <= i_cfg_data[BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_evict     <= n_evict;
        r_prod      <= n_prod;
        r_res_base  <= n_res_base;
        r_res_found <= n_res_found;
        r_res_evict <= n_res_evict;
        r_o_base    <= n_o_base;
        r_o_found   <= n_o_found;
        r_o_evict   <= n_o_evict;
    end

    a_blk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_blk) < BLOCKS)
        else $error("block index out of range");

    a_alloc_only_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_STORE) |=> $stable(r_alloc))
        else $error("allocation counter moved outside store");

    a_found_excl_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_o_found && r_o_evict))
        else $error("found and evicted both set");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_idx) < SLOTS))
        else $error("scan index out of range");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import kr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT_RSP = 150;
    localparam int DRAIN_WAIT  = 16;
    localparam int KEY_POOL    = 10;

    typedef struct packed {
        t_base region_base;
        logic  was_found;
        logic  evicted_oldest;
    } t_region_rsp;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    kr_req_if req_if ();
    kr_rsp_if rsp_if ();

    key_to_region_map_fifo_evict_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_key        key_tbl [SLOTS];
    t_base       base_tbl [SLOTS];
    t_cnt        alloc_cnt;
    t_base       cur_pool;
    t_base       cur_bsize;

    t_key        pending_keys [$];
    t_region_rsp expected_rsps [$];
    int          idle_pct = 8;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          hold_left;
    int          rsp_seen;
    logic        held;

    function automatic t_region_rsp map_request(t_key key);
        t_region_rsp r;
        logic [31:0] sum;
        t_base       fresh;
        int          free_at;
        r.region_base    = cur_pool;
        r.was_found      = 1'b0;
        r.evicted_oldest = 1'b0;
        if (key == '0) begin
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (key_tbl[i] == key) begin
                r.region_base = base_tbl[i];
                r.was_found   = 1'b1;
                return r;
            end
        end
        sum   = 32'(cur_pool) + 32'(alloc_cnt % BLOCKS) * 32'(cur_bsize);
        fresh = sum[BASE_W-1:0];
        alloc_cnt = alloc_cnt + 1'b1;
        free_at = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (key_tbl[i] == '0) begin
                free_at = i;
            end
        end
        if (free_at == SLOTS) begin
            for (int i = 1; i < SLOTS; i++) begin
                key_tbl[i-1]  = key_tbl[i];
                base_tbl[i-1] = base_tbl[i];
            end
            free_at = SLOTS - 1;
            r.evicted_oldest = 1'b1;
        end
        key_tbl[free_at]  = key;
        base_tbl[free_at] = fresh;
        r.region_base = fresh;
        return r;
    endfunction

    task automatic write_reg(input t_cfg_reg which, input t_base value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= which;
        cfg_data <= value;
        case (which)
            CFG_POOL_START: cur_pool = value;
            CFG_BLOCK_SIZE: cur_bsize = value;
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        while (pending_keys.size() != 0 || req_if.valid || expected_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sender: predict on accept, then offer the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsps.push_back(map_request(req_if.owner_key));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    req_if.valid     <= 1'b1;
                    req_if.owner_key <= pending_keys.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            rsp_seen     <= 0;
            held         <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_seen <= rsp_seen + 1;
            end
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else if (rsp_seen == HOLD_AT_RSP && !held) begin
                hold_left    <= HOLD_CYCLES;
                held         <= 1'b1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_region_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("region_base: no request outstanding, got %h", rsp_if.region_base);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_if.region_base !== want.region_base) begin
                    $error("region_base: expected %h, got %h",
                           want.region_base, rsp_if.region_base);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (rsp_if.was_found !== want.was_found) begin
                    $error("was_found: expected %b, got %b",
                           want.was_found, rsp_if.was_found);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (rsp_if.evicted_oldest !== want.evicted_oldest) begin
                    $error("evicted_oldest: expected %b, got %b",
                           want.evicted_oldest, rsp_if.evicted_oldest);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
    end

    initial begin
        t_key  seed_keys [14];
        t_key  key_pool [KEY_POOL];
        int    phase_items [6];
        int    ph;
        int    n;
        int    pick;
        t_key  k;
        t_base pool_val;
        t_base bsize_val;

        seed_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h0000_0001, 32'hDEAD_0001, 32'h0000_0002, 32'hFFFF_FFFF,
                      32'h0000_0002, 32'h0000_0000};
        phase_items = '{220, 200, 300, 200, 200, 180};

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.owner_key = '0;
        rsp_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        for (int i = 0; i < SLOTS; i++) begin
            key_tbl[i]  = '0;
            base_tbl[i] = '0;
        end
        alloc_cnt = '0;
        cur_pool  = '0;
        cur_bsize = BLOCK_SIZE_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (seed_keys[i]) begin
            pending_keys.push_back(seed_keys[i]);
        end

        for (ph = 0; ph < 6; ph++) begin
            wait_drain();
            case (ph)
                0: begin pool_val = '1; bsize_val = '1; end
                1: begin pool_val = '0; bsize_val = '0; end
                3: begin pool_val = '0; bsize_val = '1; end
                4: begin pool_val = '1; bsize_val = 16'h0001; end
                default: begin
                    pool_val  = t_base'($urandom);
                    bsize_val = t_base'($urandom);
                end
            endcase
            write_reg(CFG_POOL_START, pool_val);
            write_reg(CFG_BLOCK_SIZE, bsize_val);
            @(posedge i_clk);
            cfg_we <= 1'b0;
            idle_pct = (ph == 2) ? 0 : 8;

            foreach (key_pool[i]) begin
                key_pool[i] = t_key'($urandom);
            end
            for (n = 0; n < phase_items[ph]; n++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    k = '0;
                end else if (pick < 70) begin
                    k = key_pool[$urandom_range(KEY_POOL - 1)];
                end else begin
                    k = t_key'($urandom);
                    if (pick < 85) begin
                        key_pool[$urandom_range(KEY_POOL - 1)] = k;
                    end
                end
                pending_keys.push_back(k);
            end
        end

        wait_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
